### rtl/pwvm_pkg.sv
// Shared types, command codes and constants for the wavetable voice mixer.
// Used by every module of the mixer; depends on nothing.
`default_nettype none

package pwvm_pkg;

  typedef enum logic [2:0] {
    CMD_NOTE_ON     = 3'd0,
    CMD_NOTE_OFF    = 3'd1,
    CMD_PROGRAM     = 3'd2,
    CMD_SAMPLE_TICK = 3'd3,
    CMD_LOAD_WAVE   = 3'd4,
    CMD_LOAD_STEP   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TICK_RD,
    ST_TICK_PH,
    ST_TICK_WV,
    ST_TICK_MAC,
    ST_TICK_OUT
  } state_t;

  localparam logic [1:0] WF_HYBRID = 2'd0;
  localparam logic [1:0] WF_SINE   = 2'd1;
  localparam logic [1:0] WF_SQUARE = 2'd2;

  localparam logic [6:0] PROG_SINE_LO    = 7'd71;
  localparam logic [6:0] PROG_SINE_HI    = 7'd79;
  localparam logic [6:0] PROG_SINE_ALT_LO = 7'd52;
  localparam logic [6:0] PROG_SINE_ALT_HI = 7'd54;
  localparam logic [6:0] PROG_SQUARE     = 7'd29;

  localparam int MIX_SHIFT = 10;
  localparam int DAC_BIAS  = 2048;
  localparam int DAC_MAX   = 4095;

  typedef struct packed {
    logic        active;
    logic [6:0]  note;
    logic [3:0]  channel;
    logic [6:0]  volume;
    logic [23:0] increment;
    logic [25:0] phase;
    logic [15:0] prev_sample;
    logic [1:0]  waveform;
  } voice_t;

  typedef struct packed {
    logic clear;
    logic advance;
    logic accumulate;
  } mix_ctl_t;

  function automatic logic [1:0] program_waveform(input logic [6:0] prog);
    logic [1:0] wf;
    wf = WF_HYBRID;
    if ((prog >= PROG_SINE_LO && prog <= PROG_SINE_HI) ||
        (prog >= PROG_SINE_ALT_LO && prog <= PROG_SINE_ALT_HI)) begin
      wf = WF_SINE;
    end else if (prog == PROG_SQUARE) begin
      wf = WF_SQUARE;
    end
    return wf;
  endfunction

endpackage

`default_nettype wire

### rtl/pwvm_tables.sv
// Wave memory and step table of the mixer, each with one write and one
// registered read port. Depends on pwvm_pkg.
`default_nettype none

module pwvm_tables
  import pwvm_pkg::*;
#(
  parameter int TABLE_LENGTH   = 100,
  parameter int WAVEFORM_COUNT = 4
) (
  input  wire logic               clk,
  input  wire logic               wave_we,
  input  wire logic [1:0]         wave_wr_sel,
  input  wire logic [9:0]         wave_wr_addr,
  input  wire logic signed [15:0] wave_wr_data,
  input  wire logic               wave_re,
  input  wire logic [1:0]         wave_rd_sel,
  input  wire logic [9:0]         wave_rd_idx,
  output logic signed [15:0]      wave_rd_data,
  input  wire logic               step_we,
  input  wire logic [6:0]         step_wr_addr,
  input  wire logic [23:0]        step_wr_data,
  input  wire logic               step_re,
  input  wire logic [6:0]         step_rd_addr,
  output logic [23:0]             step_rd_data
);

  localparam int WAVE_WORDS = WAVEFORM_COUNT * TABLE_LENGTH;
  localparam int WA_W       = $clog2(WAVE_WORDS);
  localparam logic [WA_W-1:0] TL_WORDS  = WA_W'(TABLE_LENGTH);
  localparam logic [2:0]      WF_LIMIT  = 3'(WAVEFORM_COUNT);
  localparam logic [10:0]     IDX_LIMIT = 11'(TABLE_LENGTH);

  logic [15:0] wave_mem [WAVE_WORDS];
  logic [23:0] step_mem [128];

  logic [WA_W-1:0] wr_index;
  logic [WA_W-1:0] rd_index;
  logic            wr_ok;
  logic            rd_ok;
  logic [15:0]     wave_q;
  logic            wave_ok;

  always_comb begin
    wr_index = WA_W'(wave_wr_sel) * TL_WORDS + WA_W'(wave_wr_addr);
    rd_index = WA_W'(wave_rd_sel) * TL_WORDS + WA_W'(wave_rd_idx);
    wr_ok    = ({1'b0, wave_wr_sel} < WF_LIMIT) && ({1'b0, wave_wr_addr} < IDX_LIMIT);
    rd_ok    = ({1'b0, wave_rd_sel} < WF_LIMIT) && ({1'b0, wave_rd_idx} < IDX_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (wave_we && wr_ok) begin
      wave_mem[wr_index] <= wave_wr_data;
    end
    if (wave_re) begin
      wave_q  <= wave_mem[rd_index];
      wave_ok <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (step_we) begin
      step_mem[step_wr_addr] <= step_wr_data;
    end
    if (step_re) begin
      step_rd_data <= step_mem[step_rd_addr];
    end
  end

  assign wave_rd_data = wave_ok ? $signed(wave_q) : 16'sd0;

endmodule

`default_nettype wire

### rtl/pwvm_voice_bank.sv
// Per-voice state memory with one write and one registered read port.
// Entries never written since reset read as zero. Depends on pwvm_pkg.
`default_nettype none

module pwvm_voice_bank
  import pwvm_pkg::*;
#(
  parameter int VOICE_COUNT = 15,
  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    rd_en,
  input  wire logic [VIDX_W-1:0]       rd_addr,
  output voice_t                       rd_data,
  input  wire logic                    wr_en,
  input  wire logic [VIDX_W-1:0]       wr_addr,
  input  wire voice_t                  wr_data
);

  voice_t                 voice_mem [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] voice_valid;
  voice_t                 rd_q;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      voice_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= voice_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr_en) begin
        voice_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= voice_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

### rtl/pwvm_mix_unit.sv
// Shared voice arithmetic: phase advance with a single wrap, sample times
// volume accumulation, and the final scale, offset and clamp. Depends on pwvm_pkg.
`default_nettype none

module pwvm_mix_unit
  import pwvm_pkg::*;
#(
  parameter int VOICE_COUNT  = 15,
  parameter int TABLE_LENGTH = 100
) (
  input  wire logic               clk,
  input  wire mix_ctl_t           ctl,
  input  wire voice_t             voice_in,
  input  wire logic signed [15:0] sample,
  output voice_t                  work,
  output voice_t                  voice_out,
  output logic [11:0]             dac
);

  localparam int ACC_W = 20 + $clog2(VOICE_COUNT);
  localparam logic [26:0] PHASE_LIMIT = 27'(TABLE_LENGTH) << 16;

  logic [26:0]             phase_sum;
  logic [26:0]             phase_wrap;
  voice_t                  advanced;
  logic signed [15:0]      last_sel;
  logic signed [23:0]      prod;
  logic signed [23:0]      term;
  logic                    sounding;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] quot;
  logic signed [ACC_W-1:0] biased;

  always_comb begin
    phase_sum  = {1'b0, voice_in.phase} + {3'b000, voice_in.increment};
    phase_wrap = (phase_sum >= PHASE_LIMIT) ? phase_sum - PHASE_LIMIT : phase_sum;
    advanced   = voice_in;
    if (voice_in.active) begin
      advanced.phase = phase_wrap[25:0];
    end
  end

  always_comb begin
    last_sel  = work.active ? sample : $signed(work.prev_sample);
    prod      = last_sel * $signed({1'b0, work.volume});
    term      = prod >>> 4;
    sounding  = work.active || (work.volume != 7'd0);
    voice_out = work;
    voice_out.prev_sample = last_sel;
    if (!work.active && work.volume != 7'd0) begin
      voice_out.volume = work.volume - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      work <= advanced;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.accumulate && sounding) begin
      acc <= acc + ACC_W'(term);
    end
  end

  // The sum is divided by 1024 with truncation toward zero.
  always_comb begin
    quot = acc >>> MIX_SHIFT;
    if (acc[ACC_W-1] && (acc[MIX_SHIFT-1:0] != '0)) begin
      quot = quot + ACC_W'(1);
    end
    biased = quot + $signed(ACC_W'(DAC_BIAS));
    if (biased < $signed(ACC_W'(0))) begin
      dac = 12'd0;
    end else if (biased > $signed(ACC_W'(DAC_MAX))) begin
      dac = 12'(DAC_MAX);
    end else begin
      dac = biased[11:0];
    end
  end

endmodule

`default_nettype wire

### rtl/polyphonic_wavetable_voice_mixer.sv
// Top level of the wavetable voice mixer: command sequencer and channel programs.
// Depends on pwvm_pkg, pwvm_tables, pwvm_voice_bank and pwvm_mix_unit.
//
// A request is taken when start is high and busy is low. Wave loads, step loads,
// program requests and unknown commands complete in the cycle they are taken and
// leave busy low. Note-on and note-off requests scan the voice memory one voice at a
// time, reading and then checking each entry, and keep busy high until a hit or the
// last voice is checked. A sample_tick runs every voice through the shared mix unit
// (phase advance, wave memory read, multiply-accumulate), keeping busy high while
// the voices are mixed; dac_sample is then shown with done for one cycle. The
// receiver cannot stall, so every done pulse must be captured when it occurs.
`default_nettype none

module polyphonic_wavetable_voice_mixer
  import pwvm_pkg::*;
#(
  parameter int VOICE_COUNT    = 15,
  parameter int TABLE_LENGTH   = 100,
  parameter int WAVEFORM_COUNT = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         cmd,
  input  wire logic [3:0]         channel,
  input  wire logic [6:0]         key,
  input  wire logic [6:0]         velocity,
  input  wire logic [6:0]         program_req,
  input  wire logic [1:0]         table_select,
  input  wire logic [9:0]         table_address,
  input  wire logic signed [15:0] wave_value,
  input  wire logic [23:0]        step_value,
  output logic                    done,
  output logic [11:0]             dac_sample
);

  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);

  state_t state;
  state_t state_next;

  logic              accept;
  logic [VIDX_W-1:0] voice_idx;
  logic [6:0]        req_key;
  logic [3:0]        req_channel;
  logic [6:0]        req_velocity;
  logic              req_claim;
  logic [1:0]        channel_waveform [16];

  logic               bank_rd_en;
  logic [VIDX_W-1:0]  bank_rd_addr;
  voice_t             bank_rd_data;
  logic               bank_wr_en;
  voice_t             bank_wr_data;
  voice_t             scan_entry;
  logic               scan_hit;
  logic               wave_re;
  logic               wave_we;
  logic               step_we;
  logic               step_re;
  logic signed [15:0] wave_rd_data;
  logic [23:0]        step_rd_data;
  mix_ctl_t           mix_ctl;
  voice_t             mix_work;
  voice_t             mix_voice_out;
  logic [11:0]        mix_dac;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    scan_hit = req_claim ? !bank_rd_data.active
                         : (bank_rd_data.active && bank_rd_data.note == req_key);
    scan_entry           = bank_rd_data;
    scan_entry.increment = step_rd_data;
    if (req_claim) begin
      scan_entry.active   = 1'b1;
      scan_entry.note     = req_key;
      scan_entry.phase    = '0;
      scan_entry.channel  = req_channel;
      scan_entry.volume   = req_velocity;
      scan_entry.waveform = channel_waveform[req_channel];
    end else begin
      scan_entry.active  = 1'b0;
      scan_entry.channel = 4'd0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd) inside
            CMD_NOTE_ON, CMD_NOTE_OFF: state_next = ST_SCAN_RD;
            CMD_SAMPLE_TICK:           state_next = ST_TICK_RD;
            default:                   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD:  state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (scan_hit || voice_idx == LAST_VOICE) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_TICK_RD:  state_next = ST_TICK_PH;
      ST_TICK_PH:  state_next = ST_TICK_WV;
      ST_TICK_WV:  state_next = ST_TICK_MAC;
      ST_TICK_MAC: state_next = (voice_idx == LAST_VOICE) ? ST_TICK_OUT : ST_TICK_PH;
      ST_TICK_OUT: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    bank_rd_en   = 1'b0;
    bank_rd_addr = voice_idx;
    bank_wr_en   = 1'b0;
    bank_wr_data = scan_entry;
    wave_re      = 1'b0;
    mix_ctl      = '0;
    wave_we      = accept && (cmd == CMD_LOAD_WAVE);
    step_we      = accept && (cmd == CMD_LOAD_STEP);
    step_re      = accept && (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF);
    unique case (state)
      ST_IDLE:     mix_ctl.clear = accept && (cmd == CMD_SAMPLE_TICK);
      ST_SCAN_RD:  bank_rd_en = 1'b1;
      ST_SCAN_CHK: bank_wr_en = scan_hit;
      ST_TICK_RD:  bank_rd_en = 1'b1;
      ST_TICK_PH:  mix_ctl.advance = 1'b1;
      ST_TICK_WV: begin
        wave_re      = 1'b1;
        bank_rd_en   = (voice_idx != LAST_VOICE);
        bank_rd_addr = voice_idx + VIDX_W'(1);
      end
      ST_TICK_MAC: begin
        mix_ctl.accumulate = 1'b1;
        bank_wr_en         = 1'b1;
        bank_wr_data       = mix_voice_out;
      end
      ST_TICK_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      voice_idx <= '0;
      for (int c = 0; c < 16; c++) begin
        channel_waveform[c] <= WF_HYBRID;
      end
    end else begin
      state <= state_next;
      done  <= (state == ST_TICK_OUT);
      if (accept) begin
        voice_idx <= '0;
        if (cmd == CMD_PROGRAM) begin
          channel_waveform[channel] <= program_waveform(program_req);
        end
      end else if ((state == ST_SCAN_CHK && !scan_hit) || state == ST_TICK_MAC) begin
        if (voice_idx != LAST_VOICE) begin
          voice_idx <= voice_idx + VIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_key      <= key;
      req_channel  <= channel;
      req_velocity <= velocity;
      req_claim    <= (cmd == CMD_NOTE_ON) && (velocity != 7'd0);
    end
    if (state == ST_TICK_OUT) begin
      dac_sample <= mix_dac;
    end
  end

  pwvm_tables #(
    .TABLE_LENGTH  (TABLE_LENGTH),
    .WAVEFORM_COUNT(WAVEFORM_COUNT)
  ) u_tables (
    .clk         (clk),
    .wave_we     (wave_we),
    .wave_wr_sel (table_select),
    .wave_wr_addr(table_address),
    .wave_wr_data(wave_value),
    .wave_re     (wave_re),
    .wave_rd_sel (mix_work.waveform),
    .wave_rd_idx (mix_work.phase[25:16]),
    .wave_rd_data(wave_rd_data),
    .step_we     (step_we),
    .step_wr_addr(key),
    .step_wr_data(step_value),
    .step_re     (step_re),
    .step_rd_addr(key),
    .step_rd_data(step_rd_data)
  );

  pwvm_voice_bank #(
    .VOICE_COUNT(VOICE_COUNT)
  ) u_voice_bank (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (bank_rd_en),
    .rd_addr(bank_rd_addr),
    .rd_data(bank_rd_data),
    .wr_en  (bank_wr_en),
    .wr_addr(voice_idx),
    .wr_data(bank_wr_data)
  );

  pwvm_mix_unit #(
    .VOICE_COUNT (VOICE_COUNT),
    .TABLE_LENGTH(TABLE_LENGTH)
  ) u_mix_unit (
    .clk      (clk),
    .ctl      (mix_ctl),
    .voice_in (bank_rd_data),
    .sample   (wave_rd_data),
    .work     (mix_work),
    .voice_out(mix_voice_out),
    .dac      (mix_dac)
  );

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_TICK_OUT))
    else $error("done without a finished sample tick");

  assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while a request is still in progress");

  assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_SAMPLE_TICK) |=> state == ST_TICK_RD && voice_idx == '0)
    else $error("sample tick did not start at the first voice");

  assert property (@(posedge clk) disable iff (rst)
    busy |-> voice_idx <= LAST_VOICE)
    else $error("voice index beyond the last voice");

endmodule

`default_nettype wire

### tb/tb_polyphonic_wavetable_voice_mixer.sv
// Self-checking testbench for polyphonic_wavetable_voice_mixer: loads the tables,
// plays notes and program changes, and checks every DAC sample against a predictor.
// Depends on pwvm_pkg and the mixer RTL only.
module tb_polyphonic_wavetable_voice_mixer;
  import pwvm_pkg::*;

  localparam int NUM_VOICES = 15;
  localparam int WAVE_LEN = 100;
  localparam int NUM_WAVES = 4;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]         cmd;
    logic [3:0]         channel;
    logic [6:0]         key;
    logic [6:0]         velocity;
    logic [6:0]         program_req;
    logic [1:0]         table_select;
    logic [9:0]         table_address;
    logic signed [15:0] wave_value;
    logic [23:0]        step_value;
  } mixer_req_t;

  class mixer_scoreboard;
    bit               v_active[NUM_VOICES];
    bit [6:0]         v_note[NUM_VOICES];
    bit [3:0]         v_chan[NUM_VOICES];
    bit [6:0]         v_vol[NUM_VOICES];
    bit [23:0]        v_inc[NUM_VOICES];
    bit [25:0]        v_phase[NUM_VOICES];
    bit signed [15:0] v_last[NUM_VOICES];
    bit [1:0]         v_wf[NUM_VOICES];
    bit [1:0]         chan_wf[16];
    bit signed [15:0] wave_mem[NUM_WAVES * WAVE_LEN];
    bit [23:0]        step_tab[128];
    bit [11:0]        pending_samples[$];
    int               errors;
    int               requests;
    int               samples;

    function void release_note(bit [6:0] k);
      for (int v = 0; v < NUM_VOICES; v++) begin
        if (v_active[v] && v_note[v] == k) begin
          v_active[v] = 1'b0;
          v_chan[v] = '0;
          v_inc[v] = step_tab[k];
          break;
        end
      end
    endfunction

    function void note_request(mixer_req_t r);
      int        acc;
      bit [31:0] ph;
      bit [9:0]  idx;
      requests++;
      case (r.cmd)
        CMD_NOTE_ON: begin
          if (r.velocity == 0) begin
            release_note(r.key);
          end else begin
            for (int v = 0; v < NUM_VOICES; v++) begin
              if (!v_active[v]) begin
                v_note[v] = r.key;
                v_inc[v] = step_tab[r.key];
                v_phase[v] = '0;
                v_chan[v] = r.channel;
                v_active[v] = 1'b1;
                v_vol[v] = r.velocity;
                v_wf[v] = chan_wf[r.channel];
                break;
              end
            end
          end
        end
        CMD_NOTE_OFF: begin
          release_note(r.key);
        end
        CMD_PROGRAM: begin
          if ((r.program_req >= PROG_SINE_LO && r.program_req <= PROG_SINE_HI) ||
              (r.program_req >= PROG_SINE_ALT_LO && r.program_req <= PROG_SINE_ALT_HI)) begin
            chan_wf[r.channel] = WF_SINE;
          end else if (r.program_req == PROG_SQUARE) begin
            chan_wf[r.channel] = WF_SQUARE;
          end else begin
            chan_wf[r.channel] = WF_HYBRID;
          end
        end
        CMD_SAMPLE_TICK: begin
          acc = 0;
          for (int v = 0; v < NUM_VOICES; v++) begin
            if (v_active[v]) begin
              ph = 32'(v_phase[v]) + 32'(v_inc[v]);
              if (ph >= WAVE_LEN << 16) begin
                ph -= WAVE_LEN << 16;
              end
              v_phase[v] = ph[25:0];
              idx = ph[25:16];
              if (v_wf[v] < NUM_WAVES && idx < WAVE_LEN) begin
                v_last[v] = wave_mem[v_wf[v] * WAVE_LEN + idx];
              end else begin
                v_last[v] = '0;
              end
              acc += (int'(v_last[v]) * int'(v_vol[v])) >>> 4;
            end else if (v_vol[v] != 0) begin
              acc += (int'(v_last[v]) * int'(v_vol[v])) >>> 4;
              v_vol[v]--;
            end
          end
          acc = acc / (1 << MIX_SHIFT) + DAC_BIAS;
          if (acc > DAC_MAX) begin
            acc = DAC_MAX;
          end else if (acc < 0) begin
            acc = 0;
          end
          pending_samples.push_back(12'(acc));
        end
        CMD_LOAD_WAVE: begin
          if (r.table_select < NUM_WAVES && r.table_address < WAVE_LEN) begin
            wave_mem[r.table_select * WAVE_LEN + r.table_address] = r.wave_value;
          end
        end
        CMD_LOAD_STEP: begin
          step_tab[r.key] = r.step_value;
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("[tb] mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(bit [11:0] got);
      bit [11:0] want;
      samples++;
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("dac_sample %0d with no sample_tick outstanding", got));
        return;
      end
      want = pending_samples.pop_front();
      if (got != want) begin
        report_mismatch($sformatf("dac_sample got %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         cmd = '0;
  logic [3:0]         channel = '0;
  logic [6:0]         key = '0;
  logic [6:0]         velocity = '0;
  logic [6:0]         program_req = '0;
  logic [1:0]         table_select = '0;
  logic [9:0]         table_address = '0;
  logic signed [15:0] wave_value = '0;
  logic [23:0]        step_value = '0;
  logic               busy;
  logic               done;
  logic [11:0]        dac_sample;

  mixer_scoreboard sb;
  bit              burst;
  int              cycle_count;

  polyphonic_wavetable_voice_mixer dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .channel(channel),
    .key(key),
    .velocity(velocity),
    .program_req(program_req),
    .table_select(table_select),
    .table_address(table_address),
    .wave_value(wave_value),
    .step_value(step_value),
    .done(done),
    .dac_sample(dac_sample)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[tb] timeout after %0d cycles", cycle_count);
      $display("[polyphonic_wavetable_voice_mixer] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(dac_sample);
    end
  end

  function automatic mixer_req_t random_req();
    mixer_req_t r;
    r.cmd = CMD_SAMPLE_TICK;
    r.channel = 4'($urandom);
    r.key = 7'($urandom);
    r.velocity = 7'($urandom);
    r.program_req = 7'($urandom);
    r.table_select = 2'($urandom);
    r.table_address = 10'($urandom);
    r.wave_value = 16'($urandom);
    r.step_value = 24'($urandom);
    return r;
  endfunction

  task automatic issue(mixer_req_t r);
    int gap;
    start <= 1'b1;
    cmd <= r.cmd;
    channel <= r.channel;
    key <= r.key;
    velocity <= r.velocity;
    program_req <= r.program_req;
    table_select <= r.table_select;
    table_address <= r.table_address;
    wave_value <= r.wave_value;
    step_value <= r.step_value;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    mixer_req_t r;
    bit [6:0]   held[$];
    int         pick;
    int         on_weight;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Every table entry is written before any note can read it.
    burst = 1'b1;
    for (int k = 0; k < 128; k++) begin
      r = random_req();
      r.cmd = CMD_LOAD_STEP;
      r.key = 7'(k);
      if (k == 0) begin
        r.step_value = '0;
      end else if (k == 2) begin
        r.step_value = '1;
      end else if (k == 3) begin
        r.step_value = 24'(25 << 16);
      end else if (k < 120) begin
        r.step_value = 24'($urandom_range(1 << 10, 3 << 16));
      end
      issue(r);
    end
    for (int w = 0; w < NUM_WAVES; w++) begin
      for (int a = 0; a < WAVE_LEN; a++) begin
        r = random_req();
        r.cmd = CMD_LOAD_WAVE;
        r.table_select = 2'(w);
        r.table_address = 10'(a);
        if (w == WF_SQUARE) begin
          r.wave_value = (a < WAVE_LEN / 2) ? 16'sh7FFF : 16'sh8000;
        end
        issue(r);
      end
    end

    // Directed: silence, program mapping, a full voice bank driven into both
    // clamps, releases, ignored requests and unknown commands.
    burst = 1'b0;
    r = random_req();
    r.cmd = CMD_SAMPLE_TICK;
    issue(r);
    r.cmd = CMD_PROGRAM;
    r.channel = 4'd3;
    r.program_req = PROG_SQUARE;
    issue(r);
    r.channel = 4'd5;
    r.program_req = PROG_SINE_LO;
    issue(r);
    r.channel = 4'd6;
    r.program_req = PROG_SINE_ALT_HI;
    issue(r);
    repeat (NUM_VOICES + 1) begin
      r = random_req();
      r.cmd = CMD_NOTE_ON;
      r.channel = 4'd3;
      r.key = 7'd3;
      r.velocity = 7'd127;
      issue(r);
    end
    repeat (2) begin
      r = random_req();
      r.cmd = CMD_SAMPLE_TICK;
      issue(r);
    end
    r = random_req();
    r.cmd = CMD_NOTE_OFF;
    r.key = 7'd3;
    issue(r);
    r.cmd = CMD_NOTE_ON;
    r.velocity = '0;
    issue(r);
    r.cmd = CMD_NOTE_OFF;
    r.key = 7'd100;
    issue(r);
    r.cmd = CMD_SAMPLE_TICK;
    issue(r);
    r.cmd = CMD_SPARE_6;
    issue(r);
    r.cmd = CMD_SPARE_7;
    issue(r);
    r.cmd = CMD_LOAD_WAVE;
    r.table_select = WF_SINE;
    r.table_address = '1;
    issue(r);

    // Random: each block picks at random whether it leans toward filling the voice
    // bank or playing it down, with some blocks issued back to back.
    for (int blk = 0; blk < 13; blk++) begin
      burst = ($urandom_range(0, 3) == 0);
      on_weight = $urandom_range(0, 1) ? 45 : 20;
      repeat (100) begin
        r = random_req();
        pick = $urandom_range(0, 99);
        if (pick < on_weight) begin
          r.cmd = CMD_NOTE_ON;
          if ($urandom_range(0, 7) != 0) begin
            r.key = 7'($urandom_range(0, 23));
          end
          if ($urandom_range(0, 19) == 0) begin
            r.velocity = '0;
          end
        end else if (pick < on_weight + 15) begin
          r.cmd = ($urandom_range(0, 9) == 0) ? CMD_NOTE_ON : CMD_NOTE_OFF;
          r.velocity = '0;
          held.delete();
          for (int v = 0; v < NUM_VOICES; v++) begin
            if (sb.v_active[v]) begin
              held.push_back(sb.v_note[v]);
            end
          end
          if (held.size() > 0 && $urandom_range(0, 7) != 0) begin
            r.key = held[$urandom_range(0, held.size() - 1)];
          end
        end else if (pick < on_weight + 21) begin
          r.cmd = CMD_PROGRAM;
          case ($urandom_range(0, 3))
            0: r.program_req = 7'($urandom_range(50, 56));
            1: r.program_req = 7'($urandom_range(69, 81));
            2: r.program_req = 7'($urandom_range(27, 31));
            default: begin
            end
          endcase
        end else if (pick < on_weight + 26) begin
          r.cmd = CMD_LOAD_WAVE;
          if ($urandom_range(0, 7) != 0) begin
            r.table_address = 10'($urandom_range(0, WAVE_LEN - 1));
          end
        end else if (pick < on_weight + 29) begin
          r.cmd = CMD_LOAD_STEP;
          if ($urandom_range(0, 1) != 0) begin
            r.key = 7'($urandom_range(0, 23));
          end
          if ($urandom_range(0, 4) != 0) begin
            r.step_value = 24'($urandom_range(0, 4 << 16));
          end
        end else if (pick < on_weight + 30) begin
          r.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        end else begin
          r.cmd = CMD_SAMPLE_TICK;
        end
        issue(r);
      end
    end

    start <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("[tb] %0d requests accepted, %0d DAC samples checked in %0d cycles.",
             sb.requests, sb.samples, cycle_count);
    $display("[tb] Covered full and empty voice banks, releases with decay, program mapping,");
    $display("[tb] table rewrites, oversized phase steps and both output clamps.");
    if (sb.errors == 0) begin
      $display("[polyphonic_wavetable_voice_mixer] OK");
    end else begin
      $display("[polyphonic_wavetable_voice_mixer] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pwvm_pkg.sv
rtl/pwvm_tables.sv
rtl/pwvm_voice_bank.sv
rtl/pwvm_mix_unit.sv
rtl/polyphonic_wavetable_voice_mixer.sv
tb/tb_polyphonic_wavetable_voice_mixer.sv
